FILE: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/crcdfr_pkg.sv
// Shared constants, types and the CRC-16 byte update for the frame deframer.
// No dependencies.
package crcdfr_pkg;

    localparam int FRAME_BUFFER_BYTES = 64;
    localparam int HDR_BYTES          = 5;
    localparam int MIN_FRAME          = 7;
    localparam int PAYLOAD_CAP        = FRAME_BUFFER_BYTES - MIN_FRAME;
    localparam int POS_W              = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam int PIDX_W             = $clog2(PAYLOAD_CAP);
    localparam int PLEN_W             = $clog2(PAYLOAD_CAP + 1);
    localparam int RAM_AW             = PIDX_W + 1;
    localparam int RAM_DEPTH          = 1 << RAM_AW;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W          = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  START_RST = 8'h02;
    localparam logic [7:0]  END_RST   = 8'h03;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE = 2'd0,
        REG_END_BYTE   = 2'd1
    } cfg_reg_e;

    // one good frame waiting to be drained
    typedef struct packed {
        logic              bank;
        logic [7:0]        opcode;
        logic [PLEN_W-1:0] plen;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_status_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/crcdfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crcdfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: rtl/crcdfr_front.sv
// Front end: byte parser, on-the-fly CRC check and payload write into the buffer bank.
// Depends on crcdfr_pkg.
module crcdfr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  hold,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            start_byte,
    input  logic [7:0]            end_byte,
    output crcdfr_pkg::ram_wr_t   ram_wr,
    output logic                  push,
    output crcdfr_pkg::desc_t     push_desc
);
    import crcdfr_pkg::*;

    logic             inside_reg, inside_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] exp_reg, exp_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [7:0]       opcode_reg, opcode_next;
    logic             end_ok_reg, end_ok_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic             bank_reg, bank_next;

    logic             accept;
    logic [POS_W:0]   idx_x;
    logic [POS_W:0]   exp_x;
    logic [15:0]      len16;
    logic [15:0]      crc_upd;
    logic [POS_W:0]   pidx;

    assign accept  = in_valid && !hold;
    assign idx_x   = {1'b0, pos_reg};
    assign exp_x   = {1'b0, exp_reg};
    assign len16   = {rx_byte, len_lo_reg};
    assign crc_upd = crc_add(crc_reg, rx_byte);
    assign pidx    = idx_x - (POS_W+1)'(4);

    always_comb
    begin
        inside_next = inside_reg;
        pos_next    = pos_reg;
        exp_next    = exp_reg;
        crc_next    = crc_reg;
        len_lo_next = len_lo_reg;
        opcode_next = opcode_reg;
        end_ok_next = end_ok_reg;
        crc_lo_next = crc_lo_reg;
        bank_next   = bank_reg;
        ram_wr.en   = 1'b0;
        ram_wr.addr = {bank_reg, pidx[PIDX_W-1:0]};
        ram_wr.data = rx_byte;
        push        = 1'b0;
        push_desc.bank   = bank_reg;
        push_desc.opcode = opcode_reg;
        push_desc.plen   = PLEN_W'(exp_reg - POS_W'(MIN_FRAME));

        if (accept)
        begin
            if (!inside_reg)
            begin
                if (rx_byte == start_byte)
                begin
                    inside_next = 1'b1;
                    pos_next    = POS_W'(1);
                    exp_next    = '0;
                    crc_next    = CRC_INIT;
                    end_ok_next = 1'b0;
                end
            end
            else if (idx_x >= (POS_W+1)'(FRAME_BUFFER_BYTES))
            begin
                inside_next = 1'b0;
                pos_next    = '0;
                exp_next    = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (idx_x == (POS_W+1)'(1))
                begin
                    len_lo_next = rx_byte;
                    crc_next    = crc_upd;
                end
                else if (idx_x == (POS_W+1)'(2))
                begin
                    crc_next = crc_upd;
                    if (len16 < 16'(MIN_FRAME - HDR_BYTES) ||
                        len16 > 16'(FRAME_BUFFER_BYTES - HDR_BYTES))
                    begin
                        inside_next = 1'b0;
                        pos_next    = '0;
                        exp_next    = '0;
                    end
                    else
                        exp_next = POS_W'(len16 + 16'(HDR_BYTES));
                end
                else if (idx_x + (POS_W+1)'(3) <= exp_x)
                begin
                    crc_next = crc_upd;
                    if (idx_x == (POS_W+1)'(3))
                        opcode_next = rx_byte;
                    if (idx_x + (POS_W+1)'(3) == exp_x)
                        end_ok_next = (rx_byte == end_byte);
                    else if (idx_x >= (POS_W+1)'(4) && pidx < (POS_W+1)'(PAYLOAD_CAP))
                        ram_wr.en = 1'b1;
                end
                else if (idx_x + (POS_W+1)'(2) == exp_x)
                    crc_lo_next = rx_byte;
                else
                begin
                    inside_next = 1'b0;
                    pos_next    = '0;
                    exp_next    = '0;
                    if (end_ok_reg && {rx_byte, crc_lo_reg} == crc_reg)
                    begin
                        push      = 1'b1;
                        bank_next = !bank_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            pos_reg    <= '0;
            exp_reg    <= '0;
            crc_reg    <= CRC_INIT;
            end_ok_reg <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
            pos_reg    <= pos_next;
            exp_reg    <= exp_next;
            crc_reg    <= crc_next;
            end_ok_reg <= end_ok_next;
            bank_reg   <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_lo_reg <= len_lo_next;
        opcode_reg <= opcode_next;
        crc_lo_reg <= crc_lo_next;
    end

endmodule

FILE: rtl/crcdfr_queue.sv
// Two-entry descriptor queue between parser and drain; an entry leaves when its drain ends.
// Depends on crcdfr_pkg.
module crcdfr_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  crcdfr_pkg::desc_t       push_desc,
    input  logic                    pop,
    output crcdfr_pkg::desc_t       head,
    output crcdfr_pkg::q_status_t   status
);
    import crcdfr_pkg::*;

    desc_t             ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign do_push = push && (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (cnt_reg != '0);

    assign head              = ent_reg[rptr_reg];
    assign status.head_valid = (cnt_reg != '0);
    assign status.full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = do_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wptr_reg] <= push_desc;
    end

endmodule

FILE: rtl/crcdfr_back.sv
// Back end: drains a queued frame from its buffer bank into the result register.
// Depends on crcdfr_pkg.
module crcdfr_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  crcdfr_pkg::desc_t         head,
    input  logic                      head_valid,
    output logic                      pop,
    output logic                      rd_en,
    output logic [crcdfr_pkg::RAM_AW-1:0] rd_addr,
    input  logic [7:0]                rd_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                frame_opcode,
    output logic [7:0]                payload_byte,
    output logic [crcdfr_pkg::PIDX_W-1:0] payload_index,
    output logic [crcdfr_pkg::PLEN_W-1:0] payload_length,
    output logic                      has_payload,
    output logic                      last_of_frame
);
    import crcdfr_pkg::*;

    logic [PIDX_W-1:0] k_reg, k_next;
    logic              pend_reg;
    logic [7:0]        m_op_reg;
    logic [PIDX_W-1:0] m_idx_reg;
    logic [PLEN_W-1:0] m_len_reg;
    logic              m_has_reg, m_last_reg;

    logic              ov_reg;
    logic [7:0]        o_op_reg, o_byte_reg;
    logic [PIDX_W-1:0] o_idx_reg;
    logic [PLEN_W-1:0] o_len_reg;
    logic              o_has_reg, o_last_reg;

    logic out_free, issue, empty_frame, is_last;

    assign out_free    = !ov_reg || !out_stall;
    assign issue       = head_valid && !pend_reg && out_free;
    assign empty_frame = (head.plen == '0);
    assign is_last     = empty_frame || (k_reg == head.plen - PLEN_W'(1));
    assign k_next      = is_last ? '0 : k_reg + PIDX_W'(1);

    assign pop     = issue && is_last;
    assign rd_en   = issue && !empty_frame;
    assign rd_addr = {head.bank, k_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (issue)
                k_reg <= k_next;
            if (pend_reg)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m_op_reg   <= head.opcode;
            m_idx_reg  <= empty_frame ? '0 : k_reg;
            m_len_reg  <= head.plen;
            m_has_reg  <= !empty_frame;
            m_last_reg <= is_last;
        end
        if (pend_reg)
        begin
            o_op_reg   <= m_op_reg;
            o_byte_reg <= m_has_reg ? rd_data : 8'h00;
            o_idx_reg  <= m_idx_reg;
            o_len_reg  <= m_len_reg;
            o_has_reg  <= m_has_reg;
            o_last_reg <= m_last_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign frame_opcode   = o_op_reg;
    assign payload_byte   = o_byte_reg;
    assign payload_index  = o_idx_reg;
    assign payload_length = o_len_reg;
    assign has_payload    = o_has_reg;
    assign last_of_frame  = o_last_reg;

endmodule

FILE: rtl/crc16_checked_frame_deframer.sv
// Top level of the CRC-16 checked frame deframer: config registers, parser, queue, drain, buffer.
// Depends on crcdfr_pkg, crcdfr_front, crcdfr_queue, crcdfr_back, crcdfr_ram, assert_macros.svh.
//
// Frames are start, len_lo, len_hi, opcode, payload, end, crc_lo, crc_hi; the CRC-16
// (poly 0x1021, init 0xFFFF) covers length to end byte. The parser takes one byte per cycle
// while not stalled and writes the payload into one of two buffer banks, so a second frame can be
// received while the first drains. Input stalls only while both banks hold good frames not yet
// fully drained. The drain issues no new buffer read while the last one is still on its way
// to the output register. Buffer contents need no clearing after reset.
`include "assert_macros.svh"

module crc16_checked_frame_deframer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        frame_opcode,
    output logic [7:0]                        payload_byte,
    output logic [crcdfr_pkg::PIDX_W-1:0]     payload_index,
    output logic [crcdfr_pkg::PLEN_W-1:0]     payload_length,
    output logic                              has_payload,
    output logic                              last_of_frame,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crcdfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                        cfg_data
);
    import crcdfr_pkg::*;

    logic [7:0]  start_reg;
    logic [7:0]  end_reg;

    ram_wr_t     ram_wr;
    logic        push, pop;
    desc_t       push_desc, head;
    q_status_t   q_stat;
    logic        rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]  rd_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RST;
            end_reg   <= END_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_BYTE: start_reg <= cfg_data;
                REG_END_BYTE:   end_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    crcdfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .hold       (q_stat.full),
        .rx_byte    (rx_byte),
        .start_byte (start_reg),
        .end_byte   (end_reg),
        .ram_wr     (ram_wr),
        .push       (push),
        .push_desc  (push_desc)
    );

    crcdfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_stat)
    );

    crcdfr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    crcdfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (q_stat.head_valid),
        .pop            (pop),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_opcode   (frame_opcode),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .payload_length (payload_length),
        .has_payload    (has_payload),
        .last_of_frame  (last_of_frame)
    );

    `ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push, !q_stat.full, "frame pushed into full queue")
    `ASSERT_IMPL(a_bank_apart, clk, rst_n, rd_en && ram_wr.en, rd_addr[RAM_AW-1] != ram_wr.addr[RAM_AW-1], "parser writes the bank being drained")
    `ASSERT_IMPL(a_index_range, clk, rst_n, out_valid && has_payload, payload_index < payload_length, "payload index beyond length")
    `ASSERT_IMPL(a_empty_marker, clk, rst_n, out_valid && !has_payload, last_of_frame && payload_length == '0, "bad empty-frame marker")
    `ASSERT_NEXT(a_pop_frees, clk, rst_n, pop && !push && q_stat.full, !q_stat.full, "drained entry not released")

endmodule

FILE: bench/tb.sv
// Self-checking bench for crc16_checked_frame_deframer: byte stream in, payload items out.
// Depends on crcdfr_pkg and the RTL; frames are built here and predicted by a local deframer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crcdfr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_GAP    = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTED  = 30;
    localparam int FLUSH_BYTES  = FRAME_BUFFER_BYTES;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {FR_GOOD, FR_BAD_END, FR_BAD_CRC, FR_SHORT_LEN, FR_LONG_LEN, FR_CUT}
        frame_fault_e;

    typedef logic [7:0] byte_list_t[$];

    typedef struct packed {
        logic [7:0]        opcode;
        logic [7:0]        data;
        logic [PIDX_W-1:0] index;
        logic [PLEN_W-1:0] plen;
        logic              has_data;
        logic              last;
    } payload_item_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           frame_opcode;
    logic [7:0]           payload_byte;
    logic [PIDX_W-1:0]    payload_index;
    logic [PLEN_W-1:0]    payload_length;
    logic                 has_payload;
    logic                 last_of_frame;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    crc16_checked_frame_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_opcode   (frame_opcode),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .payload_length (payload_length),
        .has_payload    (has_payload),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // register copies
    logic [7:0] sof_byte = START_RST;
    logic [7:0] eof_byte = END_RST;

    // deframer state
    logic        fr_inside = 1'b0;
    int unsigned fr_pos    = 0;
    int unsigned fr_total  = 0;
    logic [15:0] fr_crc    = CRC_INIT;
    logic [7:0]  fr_len_lo = '0;
    logic [7:0]  fr_opcode = '0;
    logic        fr_end_ok = 1'b0;
    logic [7:0]  fr_crc_lo = '0;
    logic [7:0]  fr_body[PAYLOAD_CAP];

    byte_list_t    stream_q;
    payload_item_t payload_due[$];

    int          bytes_queued   = 0;
    int          bytes_accepted = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_asked     = 0;
    int          hold_served;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic report(input string what);
        if (mismatches < MAX_PRINTED)
            $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic abandon_frame();
        fr_inside = 1'b0;
        fr_pos    = 0;
        fr_total  = 0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        int unsigned   at;
        int unsigned   total;
        int unsigned   plen;
        logic [15:0]   got;
        logic          ok;
        payload_item_t r;
        if (!fr_inside)
        begin
            if (b == sof_byte)
            begin
                fr_inside = 1'b1;
                fr_pos    = 1;
                fr_total  = 0;
                fr_crc    = CRC_INIT;
                fr_end_ok = 1'b0;
            end
            return;
        end
        if (fr_pos >= FRAME_BUFFER_BYTES)
        begin
            abandon_frame();
            return;
        end
        at     = fr_pos;
        fr_pos = at + 1;
        if (at == 1)
        begin
            fr_len_lo = b;
            fr_crc    = crc16_ccitt_step(fr_crc, b);
            return;
        end
        if (at == 2)
        begin
            total  = HDR_BYTES + {b, fr_len_lo};
            fr_crc = crc16_ccitt_step(fr_crc, b);
            if (total > FRAME_BUFFER_BYTES || total < MIN_FRAME)
                abandon_frame();
            else
                fr_total = total;
            return;
        end
        if (at + 3 <= fr_total)
        begin
            fr_crc = crc16_ccitt_step(fr_crc, b);
            if (at == 3)
                fr_opcode = b;
            if (at + 3 == fr_total)
                fr_end_ok = (b == eof_byte);
            else if (at >= 4 && at - 4 < PAYLOAD_CAP)
                fr_body[at - 4] = b;
            return;
        end
        if (at + 2 == fr_total)
        begin
            fr_crc_lo = b;
            return;
        end
        // crc high byte closes the frame
        got  = {b, fr_crc_lo};
        plen = fr_total - MIN_FRAME;
        ok   = fr_end_ok && (got == fr_crc);
        abandon_frame();
        if (!ok)
            return;
        if (plen == 0)
        begin
            r          = '0;
            r.opcode   = fr_opcode;
            r.last     = 1'b1;
            payload_due.push_back(r);
            return;
        end
        for (int unsigned k = 0; k < plen && k < PAYLOAD_CAP; k++)
        begin
            r.opcode   = fr_opcode;
            r.data     = fr_body[k];
            r.index    = PIDX_W'(k);
            r.plen     = PLEN_W'(plen);
            r.has_data = 1'b1;
            r.last     = (k + 1 == plen);
            payload_due.push_back(r);
        end
    endtask

    task automatic check_result();
        payload_item_t e;
        if (payload_due.size() == 0)
        begin
            report($sformatf("unexpected item opcode %02h byte %02h", frame_opcode, payload_byte));
            return;
        end
        e = payload_due.pop_front();
        if (frame_opcode !== e.opcode)
            report($sformatf("frame_opcode %02h, want %02h", frame_opcode, e.opcode));
        if (payload_byte !== e.data)
            report($sformatf("payload_byte %02h, want %02h", payload_byte, e.data));
        if (payload_index !== e.index)
            report($sformatf("payload_index %0d, want %0d", payload_index, e.index));
        if (payload_length !== e.plen)
            report($sformatf("payload_length %0d, want %0d", payload_length, e.plen));
        if (has_payload !== e.has_data)
            report($sformatf("has_payload %b, want %b", has_payload, e.has_data));
        if (last_of_frame !== e.last)
            report($sformatf("last_of_frame %b, want %b", last_of_frame, e.last));
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                deframe_byte(rx_byte);
                bytes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (stream_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= stream_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("crc16_checked_frame_deframer: mismatch");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] opc, input byte_list_t body,
                               input frame_fault_e fault);
        logic [15:0] len;
        logic [15:0] crc;
        byte_list_t  f;
        int          keep;
        len = 16'(body.size() + 2);
        if (fault == FR_SHORT_LEN)
            len = 16'($urandom_range(1));
        else if (fault == FR_LONG_LEN)
            len = $urandom_range(1) ? 16'($urandom_range(FRAME_BUFFER_BYTES - HDR_BYTES + 1, 80))
                  : 16'($urandom_range(FRAME_BUFFER_BYTES - HDR_BYTES + 1, 16'hFFFF));
        f.push_back(sof_byte);
        f.push_back(len[7:0]);
        f.push_back(len[15:8]);
        if (fault != FR_SHORT_LEN && fault != FR_LONG_LEN)
        begin
            f.push_back(opc);
            foreach (body[i])
                f.push_back(body[i]);
            f.push_back(fault == FR_BAD_END ? eof_byte ^ 8'($urandom_range(1, 255)) : eof_byte);
            crc = CRC_INIT;
            for (int i = 1; i < f.size(); i++)
                crc = crc16_ccitt_step(crc, f[i]);
            if (fault == FR_BAD_CRC)
                crc ^= 16'($urandom_range(1, 16'hFFFF));
            f.push_back(crc[7:0]);
            f.push_back(crc[15:8]);
            if (fault == FR_CUT)
            begin
                keep = $urandom_range(1, f.size() - 1);
                f = f[0:keep-1];
            end
        end
        foreach (f[i])
            push_byte(f[i]);
    endtask

    function automatic byte_list_t random_body(input int n);
        byte_list_t  b;
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                b.push_back(8'h00);
            else if (r < 8)
                b.push_back(8'hFF);
            else if (r < 11)
                b.push_back(sof_byte);
            else
                b.push_back(8'($urandom_range(255)));
        end
        return b;
    endfunction

    function automatic int pick_plen();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6)
            return PAYLOAD_CAP;
        if (r < 14)
            return $urandom_range(9, PAYLOAD_CAP - 1);
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] non_start_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == sof_byte);
        return b;
    endfunction

    task automatic run_traffic(input int n);
        int           goal;
        int unsigned  r;
        frame_fault_e fault;
        goal = bytes_queued + n;
        while (bytes_queued < goal)
        begin
            r = $urandom_range(99);
            if (r < 95)
            begin
                if (r < 70)
                    fault = FR_GOOD;
                else if (r < 76)
                    fault = FR_BAD_END;
                else if (r < 82)
                    fault = FR_BAD_CRC;
                else if (r < 87)
                    fault = FR_SHORT_LEN;
                else if (r < 92)
                    fault = FR_LONG_LEN;
                else
                    fault = FR_CUT;
                if ($urandom_range(99) < 20)
                    repeat ($urandom_range(1, 2)) push_byte(non_start_byte());
                queue_frame(8'($urandom_range(255)), random_body(pick_plen()), fault);
            end
            else
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_input_drained();
        do
            @(posedge clk);
        while (bytes_accepted != bytes_queued);
    endtask

    task automatic settle();
        wait_input_drained();
        while (payload_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_START_BYTE)
            sof_byte = val;
        else if (idx == REG_END_BYTE)
            eof_byte = val;
    endtask

    // bring the parser back to hunting, then change both delimiters
    task automatic retune(input logic [7:0] s, input logic [7:0] e);
        settle();
        if (fr_inside)
        begin
            repeat (FLUSH_BYTES) push_byte(non_start_byte());
            settle();
        end
        write_reg(REG_START_BYTE, s);
        write_reg(REG_END_BYTE, e);
    endtask

    initial
    begin
        byte_list_t  none;
        byte_list_t  body;
        logic [7:0]  same;
        foreach (fr_body[i])
            fr_body[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frame, short length, start byte as dropping length byte,
        // start byte inside payload, bad crc
        queue_frame(8'hFF, none, FR_GOOD);
        queue_frame(8'h00, none, FR_SHORT_LEN);
        push_byte(sof_byte);
        push_byte(8'h00);
        push_byte(sof_byte);
        body.push_back(sof_byte);
        body.push_back(8'hFF);
        queue_frame(8'h00, body, FR_GOOD);
        queue_frame(8'h5A, none, FR_BAD_CRC);

        retune(8'h00, 8'hFF);
        write_reg(REG_SPARE_A, 8'($urandom_range(255)));
        write_reg(REG_SPARE_B, 8'($urandom_range(255)));
        run_traffic(30);

        retune(8'hFF, 8'h00);
        send_gap_pct = 51;
        run_traffic(30);

        retune(8'($urandom_range(255)), 8'($urandom_range(255)));
        send_gap_pct   = 0;
        recv_stall_pct = 51;
        run_traffic(15);
        settle();
        run_traffic(15);

        same = 8'($urandom_range(255));
        retune(same, same);
        send_gap_pct   = 24;
        recv_stall_pct = 24;
        run_traffic(30);

        retune(START_RST, END_RST);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_asked <= hold_asked + 1;
        repeat (2) queue_frame(8'($urandom_range(255)), random_body(10), FR_GOOD);
        queue_frame(8'($urandom_range(255)), random_body(PAYLOAD_CAP), FR_GOOD);

        retune(8'($urandom_range(255)), 8'($urandom_range(255)));
        send_gap_pct   = 24;
        recv_stall_pct = 24;
        run_traffic(30);

        settle();
        if (mismatches == 0)
            $display("crc16_checked_frame_deframer: match");
        else
            $display("crc16_checked_frame_deframer: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/crcdfr_pkg.sv
rtl/crcdfr_ram.sv
rtl/crcdfr_front.sv
rtl/crcdfr_queue.sv
rtl/crcdfr_back.sv
rtl/crc16_checked_frame_deframer.sv
bench/tb.sv
